// ----- rtl/periodic_cubic_lattice_incidence_core_defines.svh -----
// Assertion macros for the checker file of this block.
`ifndef PERIODIC_CUBIC_LATTICE_INCIDENCE_CORE_DEFINES_SVH
`define PERIODIC_CUBIC_LATTICE_INCIDENCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PLCI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PLCI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/plci_pkg.sv -----
`timescale 1ns / 1ps
package plci_pkg;

    localparam int SIDE_W   = 7;
    localparam int IDX_W    = 20;
    localparam int OP_W     = 3;
    localparam int DIR_W    = 2;
    localparam int SQ_W     = 2 * SIDE_W;
    localparam int CUBE_W   = 3 * SIDE_W;
    localparam int NB_W     = CUBE_W + 1;
    localparam int LIM_W    = CUBE_W + 2;
    localparam int CNT_W    = 3;
    localparam int TDATA_W  = 24;
    localparam int MAX_SIDE_DEF = 64;

    // floor(n/3) = (n * RECIP) >> RECIP_SH, exact for n < 2^21
    localparam int RECIP_SH = 21;
    localparam int RECIP_W  = 21;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + 2) / 3);
    localparam int PROD_W   = IDX_W + RECIP_W;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam int SIDE_RST = 4;
    localparam logic [SIDE_W-1:0] SIDE_RST_V = SIDE_W'(SIDE_RST);
    localparam logic [SQ_W-1:0]   SQ_RST_V   = SQ_W'(SIDE_RST * SIDE_RST);
    localparam logic [CUBE_W-1:0] CUBE_RST_V = CUBE_W'(SIDE_RST * SIDE_RST * SIDE_RST);
    localparam logic [CUBE_W-1:0] W1_RST_V   = CUBE_W'(SIDE_RST * SIDE_RST - SIDE_RST);
    localparam logic [CUBE_W-1:0] W2_RST_V   =
        CUBE_W'(SIDE_RST * SIDE_RST * SIDE_RST - SIDE_RST * SIDE_RST);

    // query kinds
    localparam logic [OP_W-1:0] OP_FACE_EDGES    = 3'd0;
    localparam logic [OP_W-1:0] OP_EDGE_FACES    = 3'd1;
    localparam logic [OP_W-1:0] OP_VERTEX_EDGES  = 3'd2;
    localparam logic [OP_W-1:0] OP_EDGE_VERTICES = 3'd3;
    localparam logic [OP_W-1:0] OP_CELL_FACES    = 3'd4;
    localparam logic [OP_W-1:0] OP_FACE_CELLS    = 3'd5;
    localparam logic [OP_W-1:0] OP_FACE_VERTICES = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED      = 3'd7;

    // lattice geometry derived from the side register
    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [SQ_W-1:0]   sq;
        logic [CUBE_W-1:0] cube;
        logic [CUBE_W-1:0] w1;   // L^2 - L
        logic [CUBE_W-1:0] w2;   // L^3 - L^2
    } t_geom;

    // classified query, handed from front to back
    typedef struct packed {
        logic              bad;
        logic [OP_W-1:0]   op;
        logic [DIR_W-1:0]  dir;
        logic [IDX_W-1:0]  v;
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] y;
        logic [SIDE_W-1:0] z;
    } t_item;

    typedef struct packed {
        logic              bad;
        logic [OP_W-1:0]   op;
        logic [DIR_W-1:0]  dir;
        logic [IDX_W-1:0]  v;
    } t_pre;

    typedef struct packed {
        t_pre              pre;
        logic [SIDE_W-1:0] x;
    } t_pre_x;

endpackage

// ----- rtl/plci_div.sv -----
`timescale 1ns / 1ps
module plci_div #(
    parameter int NW = 20,
    parameter int DW = 7,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_pay
);
    // restoring divider, one quotient bit per stage
    logic          r_vld [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [PW-1:0] r_pay [NW];

    logic          w_vld_in [NW];
    logic [DW-1:0] w_rem_in [NW];
    logic [NW-1:0] w_num_in [NW];
    logic [PW-1:0] w_pay_in [NW];
    logic [DW:0]   w_t      [NW];
    logic          w_ge     [NW];

    always_comb begin
        w_vld_in[0] = i_vld;
        w_rem_in[0] = '0;
        w_num_in[0] = i_num;
        w_pay_in[0] = i_pay;
        for (int k = 1; k < NW; k++) begin
            w_vld_in[k] = r_vld[k-1];
            w_rem_in[k] = r_rem[k-1];
            w_num_in[k] = r_num[k-1];
            w_pay_in[k] = r_pay[k-1];
        end
        for (int k = 0; k < NW; k++) begin
            w_t[k]  = {w_rem_in[k], w_num_in[k][NW-1]};
            w_ge[k] = (w_t[k] >= {1'b0, i_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < NW; k++) r_vld[k] <= w_vld_in[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= w_ge[k] ? DW'(w_t[k] - {1'b0, i_den}) : w_t[k][DW-1:0];
                r_num[k] <= {w_num_in[k][NW-2:0], w_ge[k]};
                r_pay[k] <= w_pay_in[k];
            end
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_quo = r_num[NW-1];
    assign o_rem = r_rem[NW-1];
    assign o_pay = r_pay[NW-1];

endmodule

// ----- rtl/plci_front.sv -----
`timescale 1ns / 1ps
module plci_front #(
    parameter int MAX_SIDE = plci_pkg::MAX_SIDE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  plci_pkg::t_geom            i_geom,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  logic [plci_pkg::OP_W-1:0]  i_op,
    input  logic [plci_pkg::IDX_W-1:0] i_idx,
    input  logic                       i_q_full,
    output logic                       o_push,
    output plci_pkg::t_item            o_item
);
    import plci_pkg::*;

    localparam int Q1_W = SQ_W;

    logic w_en;

    // stage A: range check and reciprocal product
    logic              r_a_vld;
    logic              r_a_bad;
    logic [OP_W-1:0]   r_a_op;
    logic [IDX_W-1:0]  r_a_idx;
    logic [PROD_W-1:0] r_a_prod;

    logic             w_vert_op;
    logic [LIM_W-1:0] w_lim;
    logic             w_side_bad;
    logic             w_bad;

    assign w_vert_op  = (i_op == OP_VERTEX_EDGES) || (i_op == OP_CELL_FACES);
    assign w_lim      = w_vert_op ? LIM_W'(i_geom.cube)
                                  : LIM_W'(i_geom.cube) + LIM_W'({i_geom.cube, 1'b0});
    assign w_side_bad = (i_geom.side == '0) ||
                        ({2'b00, i_geom.side} > (SIDE_W + 2)'(MAX_SIDE));
    assign w_bad      = w_side_bad || (i_op == OP_RESERVED) || (LIM_W'(i_idx) >= w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else if (w_en) r_a_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_bad  <= w_bad;
            r_a_op   <= i_op;
            r_a_idx  <= i_idx;
            r_a_prod <= PROD_W'(i_idx) * PROD_W'(RECIP);
        end
    end

    // stage B: split edge/face index into vertex and direction
    logic              r_b_vld;
    t_pre              r_b_pre;
    logic [IDX_W-1:0]  w_q3;
    logic [IDX_W-1:0]  w_r3;
    logic              w_a_vert;

    assign w_q3     = r_a_prod[RECIP_SH +: IDX_W];
    assign w_r3     = r_a_idx - w_q3 - {w_q3[IDX_W-2:0], 1'b0};
    assign w_a_vert = (r_a_op == OP_VERTEX_EDGES) || (r_a_op == OP_CELL_FACES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else if (w_en) r_b_vld <= r_a_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_pre.bad <= r_a_bad;
            r_b_pre.op  <= r_a_op;
            r_b_pre.v   <= w_a_vert ? r_a_idx : w_q3;
            r_b_pre.dir <= w_a_vert ? '0 : w_r3[DIR_W-1:0];
        end
    end

    // v / L -> x, then (v / L) / L -> y, z
    logic             w_d1_vld;
    logic [IDX_W-1:0] w_d1_quo;
    logic [SIDE_W-1:0] w_d1_rem;
    t_pre             w_d1_pay;

    plci_div #(.NW(IDX_W), .DW(SIDE_W), .PW($bits(t_pre))) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_b_vld),
        .i_num  (r_b_pre.v),
        .i_den  (i_geom.side),
        .i_pay  (r_b_pre),
        .o_vld  (w_d1_vld),
        .o_quo  (w_d1_quo),
        .o_rem  (w_d1_rem),
        .o_pay  (w_d1_pay)
    );

    t_pre_x            w_d2_in;
    logic              w_d2_vld;
    logic [Q1_W-1:0]   w_d2_quo;
    logic [SIDE_W-1:0] w_d2_rem;
    t_pre_x            w_d2_pay;

    assign w_d2_in.pre = w_d1_pay;
    assign w_d2_in.x   = w_d1_rem;

    plci_div #(.NW(Q1_W), .DW(SIDE_W), .PW($bits(t_pre_x))) u_div_yz (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_d1_vld),
        .i_num  (w_d1_quo[Q1_W-1:0]),
        .i_den  (i_geom.side),
        .i_pay  (w_d2_in),
        .o_vld  (w_d2_vld),
        .o_quo  (w_d2_quo),
        .o_rem  (w_d2_rem),
        .o_pay  (w_d2_pay)
    );

    // whole pipeline holds while its tail cannot enter the queue
    assign w_en  = !i_q_full || !w_d2_vld;
    assign o_rdy = w_en;
    assign o_push = w_d2_vld && !i_q_full;

    assign o_item.bad = w_d2_pay.pre.bad;
    assign o_item.op  = w_d2_pay.pre.op;
    assign o_item.dir = w_d2_pay.pre.dir;
    assign o_item.v   = w_d2_pay.pre.v;
    assign o_item.x   = w_d2_pay.x;
    assign o_item.y   = w_d2_rem;
    assign o_item.z   = w_d2_quo[SIDE_W-1:0];

endmodule

// ----- rtl/plci_queue.sv -----
`timescale 1ns / 1ps
module plci_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  plci_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_vld,
    output logic            o_full,
    output plci_pkg::t_item o_item
);
    import plci_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    assign o_vld  = (r_cnt != '0);
    assign o_full = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_item = r_mem[r_rd];

endmodule

// ----- rtl/plci_back.sv -----
`timescale 1ns / 1ps
module plci_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  plci_pkg::t_geom            i_geom,
    input  logic                       i_q_vld,
    input  plci_pkg::t_item            i_item,
    output logic                       o_pop,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output logic [plci_pkg::IDX_W-1:0] o_idx,
    output logic                       o_last,
    output logic                       o_err
);
    import plci_pkg::*;

    // result sources
    localparam logic [3:0] SRC_V    = 4'd0;
    localparam logic [3:0] SRC_NP   = 4'd1;   // +axis 0..2
    localparam logic [3:0] SRC_NM   = 4'd4;   // minus neighbour, axis 0..2
    localparam logic [3:0] SRC_DIAG = 4'd7;
    localparam logic [3:0] SRC_LO   = 4'd8;
    localparam logic [3:0] SRC_HI   = 4'd9;

    typedef struct packed {
        logic [3:0] src;
        logic       mul3;
        logic [1:0] add;
    } t_sel;

    function automatic t_sel mk(input logic [3:0] s, input logic m, input logic [1:0] a);
        t_sel r;
        r.src  = s;
        r.mul3 = m;
        r.add  = a;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] res_cnt(input logic [OP_W-1:0] op);
        logic [CNT_W-1:0] n;
        unique case (op)
            OP_VERTEX_EDGES, OP_CELL_FACES:    n = 3'd6;
            OP_EDGE_VERTICES, OP_FACE_CELLS:   n = 3'd2;
            OP_RESERVED:                       n = 3'd1;
            default:                           n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic t_sel sel(input logic [OP_W-1:0] op, input logic [DIR_W-1:0] d,
                                 input logic [CNT_W-1:0] k);
        logic [1:0] a;
        logic [1:0] b;
        t_sel       r;
        a = (d == 2'd2) ? 2'd1 : 2'd0;
        b = (d == 2'd0) ? 2'd1 : 2'd2;
        r = mk(SRC_V, 1'b0, 2'd0);
        unique case (op)
            OP_FACE_EDGES: begin
                unique case (k)
                    3'd0:    r = mk(SRC_V, 1'b1, a);
                    3'd1:    r = mk(SRC_V, 1'b1, b);
                    3'd2:    r = mk(SRC_NP + 4'(a), 1'b1, b);
                    default: r = mk(SRC_NP + 4'(b), 1'b1, a);
                endcase
            end
            OP_EDGE_FACES: begin
                unique case (d)
                    2'd0: begin
                        unique case (k)
                            3'd0:    r = mk(SRC_V, 1'b1, 2'd0);
                            3'd1:    r = mk(SRC_V, 1'b1, 2'd1);
                            3'd2:    r = mk(SRC_NM + 4'd1, 1'b1, 2'd0);
                            default: r = mk(SRC_NM + 4'd2, 1'b1, 2'd1);
                        endcase
                    end
                    2'd1: begin
                        unique case (k)
                            3'd0:    r = mk(SRC_V, 1'b1, 2'd0);
                            3'd1:    r = mk(SRC_V, 1'b1, 2'd2);
                            3'd2:    r = mk(SRC_NM + 4'd0, 1'b1, 2'd0);
                            default: r = mk(SRC_NM + 4'd2, 1'b1, 2'd2);
                        endcase
                    end
                    default: begin
                        unique case (k)
                            3'd0:    r = mk(SRC_V, 1'b1, 2'd2);
                            3'd1:    r = mk(SRC_V, 1'b1, 2'd1);
                            3'd2:    r = mk(SRC_NM + 4'd1, 1'b1, 2'd2);
                            default: r = mk(SRC_NM + 4'd0, 1'b1, 2'd1);
                        endcase
                    end
                endcase
            end
            OP_VERTEX_EDGES: begin
                unique case (k)
                    3'd0:    r = mk(SRC_V, 1'b1, 2'd0);
                    3'd1:    r = mk(SRC_V, 1'b1, 2'd1);
                    3'd2:    r = mk(SRC_V, 1'b1, 2'd2);
                    3'd3:    r = mk(SRC_NM + 4'd0, 1'b1, 2'd0);
                    3'd4:    r = mk(SRC_NM + 4'd1, 1'b1, 2'd1);
                    default: r = mk(SRC_NM + 4'd2, 1'b1, 2'd2);
                endcase
            end
            OP_EDGE_VERTICES: begin
                r = (k == 3'd0) ? mk(SRC_V, 1'b0, 2'd0) : mk(SRC_NP + 4'(d), 1'b0, 2'd0);
            end
            OP_CELL_FACES: begin
                unique case (k)
                    3'd0:    r = mk(SRC_V, 1'b1, 2'd0);
                    3'd1:    r = mk(SRC_V, 1'b1, 2'd1);
                    3'd2:    r = mk(SRC_V, 1'b1, 2'd2);
                    3'd3:    r = mk(SRC_NP + 4'd2, 1'b1, 2'd0);
                    3'd4:    r = mk(SRC_NP + 4'd1, 1'b1, 2'd1);
                    default: r = mk(SRC_NP + 4'd0, 1'b1, 2'd2);
                endcase
            end
            OP_FACE_CELLS: begin
                r = (k == 3'd0) ? mk(SRC_LO, 1'b0, 2'd0) : mk(SRC_HI, 1'b0, 2'd0);
            end
            OP_FACE_VERTICES: begin
                unique case (k)
                    3'd0:    r = mk(SRC_V, 1'b0, 2'd0);
                    3'd1:    r = mk(SRC_NP + 4'(a), 1'b0, 2'd0);
                    3'd2:    r = mk(SRC_NP + 4'(b), 1'b0, 2'd0);
                    default: r = mk(SRC_DIAG, 1'b0, 2'd0);
                endcase
            end
            default: r = mk(SRC_V, 1'b0, 2'd0);
        endcase
        return r;
    endfunction

    // neighbor precompute on the queue head
    logic [SIDE_W-1:0] w_c      [3];
    logic [NB_W-1:0]   w_stride [3];
    logic [NB_W-1:0]   w_wrap   [3];
    logic [NB_W-1:0]   w_dup    [3];
    logic [NB_W-1:0]   w_np     [3];
    logic [NB_W-1:0]   w_nm     [3];
    logic [NB_W-1:0]   w_v;
    logic [NB_W-1:0]   w_diag;
    logic [NB_W-1:0]   w_t;
    logic [1:0]        w_a;
    logic [1:0]        w_b;
    logic [SIDE_W-1:0] w_lm1;

    assign w_c[0]      = i_item.x;
    assign w_c[1]      = i_item.y;
    assign w_c[2]      = i_item.z;
    assign w_lm1       = i_geom.side - 1'b1;
    assign w_stride[0] = NB_W'(1);
    assign w_stride[1] = NB_W'(i_geom.side);
    assign w_stride[2] = NB_W'(i_geom.sq);
    assign w_wrap[0]   = NB_W'(w_lm1);
    assign w_wrap[1]   = NB_W'(i_geom.w1);
    assign w_wrap[2]   = NB_W'(i_geom.w2);
    assign w_v         = NB_W'(i_item.v);
    assign w_a         = (i_item.dir == 2'd2) ? 2'd1 : 2'd0;
    assign w_b         = (i_item.dir == 2'd0) ? 2'd1 : 2'd2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dup[i] = (w_c[i] == w_lm1) ? NB_W'(0) - w_wrap[i] : w_stride[i];
            w_np[i]  = w_v + w_dup[i];
            w_nm[i]  = (w_c[i] == '0) ? w_v + w_wrap[i] : w_v - w_stride[i];
        end
        w_diag = w_v + w_dup[w_a] + w_dup[w_b];
        unique case (i_item.dir)
            2'd0:    w_t = w_nm[2];
            2'd1:    w_t = w_nm[1];
            default: w_t = w_nm[0];
        endcase
    end

    // work register
    logic              r_w_vld;
    logic              r_w_bad;
    logic [OP_W-1:0]   r_w_op;
    logic [DIR_W-1:0]  r_w_dir;
    logic [CNT_W-1:0]  r_w_cnt;
    logic [CNT_W-1:0]  r_k;
    logic [NB_W-1:0]   r_w_v;
    logic [NB_W-1:0]   r_w_np [3];
    logic [NB_W-1:0]   r_w_nm [3];
    logic [NB_W-1:0]   r_w_diag;
    logic [NB_W-1:0]   r_w_lo;
    logic [NB_W-1:0]   r_w_hi;

    logic w_out_free;
    logic w_fire;
    logic w_last;
    logic w_pop;

    assign w_out_free = !o_vld || i_rdy;
    assign w_fire     = r_w_vld && w_out_free;
    assign w_last     = r_w_bad || (r_k == r_w_cnt - 1'b1);
    assign w_pop      = i_q_vld && (!r_w_vld || (w_fire && w_last));
    assign o_pop      = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
            r_k     <= '0;
        end else if (w_pop) begin
            r_w_vld <= 1'b1;
            r_k     <= '0;
        end else if (w_fire) begin
            if (w_last) r_w_vld <= 1'b0;
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_w_bad  <= i_item.bad;
            r_w_op   <= i_item.op;
            r_w_dir  <= i_item.dir;
            r_w_cnt  <= res_cnt(i_item.op);
            r_w_v    <= w_v;
            r_w_diag <= w_diag;
            r_w_lo   <= (w_v < w_t) ? w_v : w_t;
            r_w_hi   <= (w_v < w_t) ? w_t : w_v;
            for (int i = 0; i < 3; i++) begin
                r_w_np[i] <= w_np[i];
                r_w_nm[i] <= w_nm[i];
            end
        end
    end

    // per-result selection
    t_sel             w_sel;
    logic [NB_W-1:0]  w_base;
    logic [IDX_W-1:0] w_res;

    always_comb begin
        w_sel = sel(r_w_op, r_w_dir, r_k);
        unique case (w_sel.src)
            SRC_V:         w_base = r_w_v;
            SRC_NP:        w_base = r_w_np[0];
            SRC_NP + 4'd1: w_base = r_w_np[1];
            SRC_NP + 4'd2: w_base = r_w_np[2];
            SRC_NM:        w_base = r_w_nm[0];
            SRC_NM + 4'd1: w_base = r_w_nm[1];
            SRC_NM + 4'd2: w_base = r_w_nm[2];
            SRC_DIAG:      w_base = r_w_diag;
            SRC_LO:        w_base = r_w_lo;
            SRC_HI:        w_base = r_w_hi;
            default:       w_base = r_w_v;
        endcase
        if (r_w_bad)       w_res = '0;
        else if (w_sel.mul3)
            w_res = IDX_W'(w_base + {w_base[NB_W-2:0], 1'b0} + NB_W'(w_sel.add));
        else
            w_res = IDX_W'(w_base);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else if (w_fire) o_vld <= 1'b1;
        else if (i_rdy) o_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_idx  <= w_res;
            o_last <= w_last;
            o_err  <= r_w_bad;
        end
    end

endmodule

// ----- rtl/periodic_cubic_lattice_incidence_core.sv -----
`timescale 1ns / 1ps
// Incidence queries on a periodic L x L x L cubic lattice.
// Input stream (s_*): tuser = query kind, tdata = element index; one
// transfer per query. Output stream (m_*): one transfer per incident element,
// tlast on the final one, tuser = range error (a single zero result flagged).
// APB port: register 0 at byte address 0 holds the side length L (reset 4).
// Write it only while the block is drained; derived L^2, L^3 are loaded
// together with L, so a query may follow right after the write.
// Path: the front end is a pipeline (reciprocal divide by 3, then two restoring
// dividers, one quotient bit per stage, splitting the vertex into x, y, z),
// followed by the queue, the back end work register and the output register.
// Throughput: the back end emits one result per cycle while the receiver is
// ready; a query yields 2, 4 or 6 results by kind (1 for a rejected query),
// and queries follow each other with no gap.
// A 4-entry queue sits between front and back. When the receiver stalls the
// output register holds; the back end stops, the queue fills and then the
// front pipeline freezes and s_tready drops. Reset empties all stages.
module periodic_cubic_lattice_incidence_core #(
    parameter int MAX_SIDE = plci_pkg::MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // query stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [plci_pkg::TDATA_W-1:0]  i_s_tdata,  // [19:0] element_index
    input  logic [plci_pkg::OP_W-1:0]     i_s_tuser,  // [2:0] opcode
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [plci_pkg::TDATA_W-1:0]  o_m_tdata,  // [19:0] neighbour_index
    output logic                          o_m_tlast,
    output logic                          o_m_tuser   // [0] range_error
);
    import plci_pkg::*;

    // configuration and derived geometry
    logic [SIDE_W-1:0] r_side;
    logic [SQ_W-1:0]   r_sq;
    logic [CUBE_W-1:0] r_cube;
    logic [CUBE_W-1:0] r_w1;
    logic [CUBE_W-1:0] r_w2;
    logic [SIDE_W-1:0] n_side;
    logic [SQ_W-1:0]   n_sq;
    logic [CUBE_W-1:0] n_cube;
    logic [CUBE_W-1:0] n_w1;
    logic [CUBE_W-1:0] n_w2;
    logic              w_wr;
    t_geom             w_geom;

    assign w_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_side) : 32'd0;

    // whole geometry computed from the written value
    assign n_side = pwdata[SIDE_W-1:0];
    assign n_sq   = SQ_W'(n_side) * SQ_W'(n_side);
    assign n_cube = CUBE_W'(n_sq) * CUBE_W'(n_side);
    assign n_w1   = CUBE_W'(n_sq) - CUBE_W'(n_side);
    assign n_w2   = n_cube - CUBE_W'(n_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RST_V;
            r_sq   <= SQ_RST_V;
            r_cube <= CUBE_RST_V;
            r_w1   <= W1_RST_V;
            r_w2   <= W2_RST_V;
        end else if (w_wr) begin
            r_side <= n_side;
            r_sq   <= n_sq;
            r_cube <= n_cube;
            r_w1   <= n_w1;
            r_w2   <= n_w2;
        end
    end

    assign w_geom.side = r_side;
    assign w_geom.sq   = r_sq;
    assign w_geom.cube = r_cube;
    assign w_geom.w1   = r_w1;
    assign w_geom.w2   = r_w2;

    // front: classify and split index
    logic  w_push;
    logic  w_q_full;
    logic  w_q_vld;
    logic  w_pop;
    t_item w_f_item;
    t_item w_q_item;
    logic [IDX_W-1:0] w_res_idx;

    plci_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_op    (i_s_tuser),
        .i_idx   (i_s_tdata[IDX_W-1:0]),
        .i_q_full(w_q_full),
        .o_push  (w_push),
        .o_item  (w_f_item)
    );

    plci_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_f_item),
        .i_pop  (w_pop),
        .o_vld  (w_q_vld),
        .o_full (w_q_full),
        .o_item (w_q_item)
    );

    // back: one result transfer per cycle while the receiver is ready
    plci_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_geom (w_geom),
        .i_q_vld(w_q_vld),
        .i_item (w_q_item),
        .o_pop  (w_pop),
        .o_vld  (o_m_tvalid),
        .i_rdy  (i_m_tready),
        .o_idx  (w_res_idx),
        .o_last (o_m_tlast),
        .o_err  (o_m_tuser)
    );

    assign o_m_tdata = TDATA_W'(w_res_idx);

endmodule

// ----- rtl/plci_checker.sv -----
`timescale 1ns / 1ps
`include "periodic_cubic_lattice_incidence_core_defines.svh"
module plci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);
    // a rejected query is a single, zero-valued, final result
    `PLCI_ASSERT_IMP(a_err_last, o_m_tvalid && o_m_tuser, o_m_tlast, "error result without tlast")
    `PLCI_ASSERT_IMP(a_err_zero, o_m_tvalid && o_m_tuser, o_m_tdata == 24'd0, "error result nonzero")
    // result index never exceeds the 20-bit field
    `PLCI_ASSERT_IMP(a_pad_zero, o_m_tvalid, o_m_tdata[23:20] == 4'd0, "tdata padding nonzero")
    // stalled result holds
    `PLCI_ASSERT_NXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stall lost")
endmodule

bind periodic_cubic_lattice_incidence_core plci_checker u_plci_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import plci_pkg::*;

    // Expected incidence lists, one entry per result transfer.
    class incidence_board;
        logic [IDX_W-1:0] exp_idx[$];
        bit               exp_last[$];
        bit               exp_err[$];
        int               errors;
        int unsigned      side;

        function new();
            errors = 0;
            side   = 4;
        endfunction

        // wrapped neighbour of vertex v along axis d
        function int unsigned step_nb(int unsigned v, int d, bit up);
            int unsigned c[3];
            int unsigned L;
            L = side;
            c[0] = v % L;
            c[1] = (v / L) % L;
            c[2] = (v / (L * L)) % L;
            if (up) c[d] = (c[d] + 1) % L;
            else c[d] = (c[d] + L - 1) % L;
            return c[0] + c[1] * L + c[2] * L * L;
        endfunction

        function void push(int unsigned val, bit err);
            exp_idx  = {exp_idx, val[IDX_W-1:0]};
            exp_last = {exp_last, 1'b0};
            exp_err  = {exp_err, err};
        endfunction

        // note an accepted query and queue its incident elements
        function void note_query(logic [OP_W-1:0] op, int unsigned idx);
            int unsigned cells, lim, v, t, d, a, b;
            if (side == 0 || side > MAX_SIDE_DEF || op == OP_RESERVED) begin
                push(0, 1);
                exp_last[$] = 1;
                return;
            end
            cells = side * side * side;
            lim = (op == OP_VERTEX_EDGES || op == OP_CELL_FACES) ? cells : 3 * cells;
            if (idx >= lim) begin
                push(0, 1);
                exp_last[$] = 1;
                return;
            end
            if (op == OP_VERTEX_EDGES || op == OP_CELL_FACES) begin
                v = idx;
                d = 0;
            end else begin
                v = idx / 3;
                d = idx % 3;
            end
            a = (d == 2) ? 1 : 0;
            b = (d == 0) ? 1 : 2;
            case (op)
                OP_FACE_EDGES: begin
                    push(3 * v + a, 0);
                    push(3 * v + b, 0);
                    push(3 * step_nb(v, a, 1) + b, 0);
                    push(3 * step_nb(v, b, 1) + a, 0);
                end
                OP_EDGE_FACES: begin
                    if (d == 0) begin
                        push(3 * v, 0);
                        push(3 * v + 1, 0);
                        push(3 * step_nb(v, 1, 0), 0);
                        push(3 * step_nb(v, 2, 0) + 1, 0);
                    end else if (d == 1) begin
                        push(3 * v, 0);
                        push(3 * v + 2, 0);
                        push(3 * step_nb(v, 0, 0), 0);
                        push(3 * step_nb(v, 2, 0) + 2, 0);
                    end else begin
                        push(3 * v + 2, 0);
                        push(3 * v + 1, 0);
                        push(3 * step_nb(v, 1, 0) + 2, 0);
                        push(3 * step_nb(v, 0, 0) + 1, 0);
                    end
                end
                OP_VERTEX_EDGES: begin
                    push(3 * v, 0);
                    push(3 * v + 1, 0);
                    push(3 * v + 2, 0);
                    push(3 * step_nb(v, 0, 0), 0);
                    push(3 * step_nb(v, 1, 0) + 1, 0);
                    push(3 * step_nb(v, 2, 0) + 2, 0);
                end
                OP_EDGE_VERTICES: begin
                    push(v, 0);
                    push(step_nb(v, d, 1), 0);
                end
                OP_CELL_FACES: begin
                    push(3 * v, 0);
                    push(3 * v + 1, 0);
                    push(3 * v + 2, 0);
                    push(3 * step_nb(v, 2, 1), 0);
                    push(3 * step_nb(v, 1, 1) + 1, 0);
                    push(3 * step_nb(v, 0, 1) + 2, 0);
                end
                OP_FACE_CELLS: begin
                    t = step_nb(v, 2 - d, 0);
                    push((v < t) ? v : t, 0);
                    push((v < t) ? t : v, 0);
                end
                default: begin
                    t = step_nb(v, a, 1);
                    push(v, 0);
                    push(t, 0);
                    push(step_nb(v, b, 1), 0);
                    push(step_nb(t, b, 1), 0);
                end
            endcase
            exp_last[$] = 1;
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, bit last, bit err);
            if (exp_idx.size() == 0) begin
                $display("%0t: unexpected result idx=%0d last=%0b err=%0b",
                         $time, idx, last, err);
                errors++;
                return;
            end
            if (idx !== exp_idx[0] || last !== exp_last[0] || err !== exp_err[0]) begin
                $display("%0t: expected idx=%0d last=%0b err=%0b, got idx=%0d last=%0b err=%0b",
                         $time, exp_idx[0], exp_last[0], exp_err[0], idx, last, err);
                errors++;
            end
            void'(exp_idx.pop_front());
            void'(exp_last.pop_front());
            void'(exp_err.pop_front());
        endfunction
    endclass

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                psel = 0, penable = 0, pwrite = 0;
    logic [2:0]          paddr = 0;
    logic [31:0]         pwdata = 0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_s_tvalid = 0;
    logic                o_s_tready;
    logic [TDATA_W-1:0]  i_s_tdata = 0;   // [19:0] element_index
    logic [OP_W-1:0]     i_s_tuser = 0;   // [2:0] opcode
    logic                o_m_tvalid;
    logic                i_m_tready = 0;
    logic [TDATA_W-1:0]  o_m_tdata;       // [19:0] neighbour_index
    logic                o_m_tlast;
    logic                o_m_tuser;       // [0] range_error

    incidence_board board = new();
    bit             rx_stall_on;          // receiver stalls enabled

    periodic_cubic_lattice_incidence_core dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: sample at the rising edge, toggle ready at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata[IDX_W-1:0], o_m_tlast, o_m_tuser);
    end

    initial begin : rx_side
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_m_tready <= 1;
            @(posedge i_clk);
            // hold ready until a transfer happens, then maybe stall
            while (!o_m_tvalid) @(posedge i_clk);
            g = rx_stall_on ? gap_len() : 0;
            if (g > 0) begin
                @(negedge i_clk);
                i_m_tready <= 0;
                repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= addr;
        pwdata  <= data;
        penable <= 0;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == 3'd0) board.side = data & 32'h7F;
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // one query transfer; gap ahead of it when idling is on
    task automatic send_query(input logic [OP_W-1:0] op, input int unsigned idx,
                              input bit idle);
        int g;
        g = idle ? gap_len() : 0;
        @(negedge i_clk);
        if (g > 0) begin
            i_s_tvalid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= op;
        i_s_tdata  <= TDATA_W'(idx);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_query(op, idx);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 0;
        while (board.exp_idx.size() != 0) @(posedge i_clk);
        // rejected-looking queries still in flight: let the pipeline empty
        repeat (80) @(posedge i_clk);
    endtask

    // random query; mostly in range, sometimes out of range or reserved
    task automatic random_query(input bit idle);
        logic [OP_W-1:0] op;
        int unsigned     lim, idx;
        int              r;
        op  = OP_W'($urandom_range(0, 6));
        r   = $urandom_range(0, 99);
        lim = board.side * board.side * board.side;
        if (!(op == OP_VERTEX_EDGES || op == OP_CELL_FACES)) lim = 3 * lim;
        if (r < 4) op = OP_RESERVED;
        if (r < 12 || lim == 0) idx = $urandom_range(0, (1 << IDX_W) - 1);
        else if (r < 15) idx = lim - 1;
        else idx = $urandom_range(0, lim - 1);
        send_query(op, idx, idle);
    endtask

    initial begin : main
        int sides[8] = '{4, 1, 2, 3, 64, 7, 0, 65};
        int unsigned lim;
        rx_stall_on = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: every query kind at both ends of the range, reset side
        for (int op = 0; op < 7; op++) begin
            lim = (op == OP_VERTEX_EDGES || op == OP_CELL_FACES) ? 64 : 192;
            send_query(OP_W'(op), 0, 0);
            send_query(OP_W'(op), lim - 1, 0);
        end
        send_query(OP_FACE_EDGES, 192, 0);          // just past the end
        send_query(OP_CELL_FACES, 64, 0);
        send_query(OP_RESERVED, 5, 0);
        send_query(OP_EDGE_FACES, 20'hFFFFF, 0);    // all index bits set
        drain();

        // random phases over several side lengths, extremes and bad ones
        for (int ph = 0; ph < 8; ph++) begin
            apb_write(3'd0, sides[ph]);
            if (ph == 2) apb_write(3'd4, 32'hFFFF_FFFF);   // unknown register
            rx_stall_on = (ph % 3 != 1);
            for (int k = 0; k < ((sides[ph] == 0 || sides[ph] > 64) ? 20 : 70); k++)
                random_query(ph % 3 != 2);
            drain();
        end

        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/plci_pkg.sv
rtl/plci_div.sv
rtl/plci_front.sv
rtl/plci_queue.sv
rtl/plci_back.sv
rtl/periodic_cubic_lattice_incidence_core.sv
rtl/plci_checker.sv
tb/testbench.sv
